/* rtl/ctms_pkg.sv */
// Shared constants and types for the chunked tile map store.
// Depends on nothing; chunked_tile_map_store and ctms_addr import it.
package ctms_pkg;

    // Store geometry
    localparam int MAX_CHUNKS      = 64;
    localparam int MAX_CHUNK_SHIFT = 4;
    localparam int TILE_BITS       = 8;

    // Field widths
    localparam int COORD_W    = 32;
    localparam int VALUE_W    = 8;
    localparam int SHIFT_W    = 3;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COUNT_W;

    // Derived sizes
    localparam int SLOT_AW         = 2 * MAX_CHUNK_SHIFT;
    localparam int SLOTS_PER_CHUNK = 1 << SLOT_AW;
    localparam int CHUNK_AW        = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int STORE_DEPTH     = MAX_CHUNKS * SLOTS_PER_CHUNK;
    localparam int STORE_AW        = $clog2(STORE_DEPTH);
    localparam int VAL_W           = (TILE_BITS < VALUE_W) ? TILE_BITS : VALUE_W;
    localparam int SH_W            = $clog2(MAX_CHUNK_SHIFT + 1);

    // Configuration register set
    typedef struct packed {
        logic [SHIFT_W-1:0] chunk_shift;
        logic [COUNT_W-1:0] count_x;
        logic [COUNT_W-1:0] count_y;
        logic [COUNT_W-1:0] count_z;
    } t_cfg;

    // Resolved location of one access
    typedef struct packed {
        logic                in_range;
        logic [CHUNK_AW-1:0] chunk;
        logic [SLOT_AW-1:0]  offset;
    } t_addr;

endpackage

/* rtl/chunked_tile_map_store.sv */
// Chunked tile map store: one result per access, registered in S_RESP after acceptance.
// One access at a time, taken only when idle or as the last one finishes, paced by the
// two-stage index multiply and the RAM read ahead of the read-modify-write cycle.
// Reset: config registers take their defaults and the chunk allocation flags clear at
// once; no clearing pass, a chunk's written-bit row is rebuilt when it is allocated.
// Depends on ctms_pkg, ctms_addr and ctms_ram.
module chunked_tile_map_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Access channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [ctms_pkg::COORD_W-1:0]  i_tile_x,
    input  logic [ctms_pkg::COORD_W-1:0]  i_tile_y,
    input  logic [ctms_pkg::COORD_W-1:0]  i_tile_z,
    input  logic [ctms_pkg::VALUE_W-1:0]  i_write_value,
    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ctms_pkg::VALUE_W-1:0]  o_tile_value,
    output logic                          o_in_range,
    output logic                          o_chunk_present,
    output logic                          o_passable,
    // Configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ctms_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ctms_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ctms_pkg::*;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHIFT   = 2'd0,
        CFG_COUNT_X = 2'd1,
        CFG_COUNT_Y = 2'd2,
        CFG_COUNT_Z = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_RESP
    } t_state;

    // Tile codes the game treats as passable; floor is also the unwritten default
    localparam logic [VALUE_W-1:0] TILE_FLOOR = VALUE_W'(1);
    localparam logic [VALUE_W-1:0] TILE_DOOR  = VALUE_W'(3);
    localparam logic [VALUE_W-1:0] TILE_RAMP  = VALUE_W'(4);

    t_state                 r_state;
    t_cfg                   r_cfg;
    logic [MAX_CHUNKS-1:0]  r_alloc;
    logic                   r_kind;
    logic [VAL_W-1:0]       r_wval;
    logic                   r_out_valid;
    logic [VALUE_W-1:0]     r_out_value;
    logic                   r_out_in_range;
    logic                   r_out_present;
    logic                   r_out_passable;

    logic                       accept;
    logic                       finish;
    logic                       addr_done;
    t_addr                      addr;
    logic                       present;
    logic                       mem_we;
    logic [SLOTS_PER_CHUNK-1:0] row_rdata;
    logic [SLOTS_PER_CHUNK-1:0] row_onehot;
    logic [SLOTS_PER_CHUNK-1:0] row_wdata;
    logic [VAL_W-1:0]           tile_rdata;
    logic [STORE_AW-1:0]        tile_addr;
    logic [VALUE_W-1:0]         rd_value;
    logic [VALUE_W-1:0]         res_value;

    // Handshakes
    assign finish      = (r_state == S_RESP) && (!r_out_valid || i_out_ready);
    assign o_in_ready  = (r_state == S_IDLE) || finish;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chunk_shift <= SHIFT_W'(4);
            r_cfg.count_x     <= COUNT_W'(4);
            r_cfg.count_y     <= COUNT_W'(4);
            r_cfg.count_z     <= COUNT_W'(1);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SHIFT:   r_cfg.chunk_shift <= i_cfg_data[SHIFT_W-1:0];
                CFG_COUNT_X: r_cfg.count_x     <= i_cfg_data;
                CFG_COUNT_Y: r_cfg.count_y     <= i_cfg_data;
                CFG_COUNT_Z: r_cfg.count_z     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Access fields held for the read-modify-write cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_wval <= i_write_value[VAL_W-1:0];
        end
    end

    ctms_addr u_addr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_tile_x (i_tile_x),
        .i_tile_y (i_tile_y),
        .i_tile_z (i_tile_z),
        .i_cfg    (r_cfg),
        .o_done   (addr_done),
        .o_addr   (addr)
    );

    // Tile values and per-chunk written-bit rows
    assign tile_addr = STORE_AW'({addr.chunk, addr.offset});

    ctms_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STORE_DEPTH)
    ) u_tile_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (tile_addr),
        .i_wdata (r_wval),
        .i_re    (addr_done),
        .i_raddr (tile_addr),
        .o_rdata (tile_rdata)
    );

    ctms_ram #(
        .WIDTH (SLOTS_PER_CHUNK),
        .DEPTH (MAX_CHUNKS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (addr.chunk),
        .i_wdata (row_wdata),
        .i_re    (addr_done),
        .i_raddr (addr.chunk),
        .o_rdata (row_rdata)
    );

    // Read-modify-write: a fresh chunk starts its row with only this tile marked
    assign present    = addr.in_range && r_alloc[addr.chunk];
    assign mem_we     = finish && r_kind && addr.in_range;
    assign row_onehot = SLOTS_PER_CHUNK'(1) << addr.offset;
    assign row_wdata  = present ? (row_rdata | row_onehot) : row_onehot;

    always_comb begin
        if (!present) begin
            rd_value = '0;
        end else if (row_rdata[addr.offset]) begin
            rd_value = VALUE_W'(tile_rdata);
        end else begin
            rd_value = TILE_FLOOR;
        end
    end

    assign res_value = r_kind ? VALUE_W'(r_wval) : rd_value;

    // Chunk allocation flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc <= '0;
        end else if (mem_we) begin
            r_alloc[addr.chunk] <= 1'b1;
        end
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a finishing transaction reloads the result register instead
            if (o_out_valid && i_out_ready && !finish) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    if (addr_done) begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (finish) begin
                        r_out_valid    <= 1'b1;
                        r_out_value    <= res_value;
                        r_out_in_range <= addr.in_range;
                        r_out_present  <= present;
                        r_out_passable <= !r_kind && ((rd_value == TILE_FLOOR) ||
                                          (rd_value == TILE_DOOR) || (rd_value == TILE_RAMP));
                        r_state        <= accept ? S_ADDR : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tile_value    = r_out_value;
    assign o_in_range      = r_out_in_range;
    assign o_chunk_present = r_out_present;
    assign o_passable      = r_out_passable;

    // Checks
    a_done_in_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        addr_done |-> (r_state == S_ADDR))
        else $error("address result arrived outside the address wait");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> r_out_valid)
        else $error("finished transaction did not load the result register");

    a_oor_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_in_range) |-> !r_out_present)
        else $error("out-of-range result flagged chunk present");

    a_write_allocates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_alloc[$past(addr.chunk)])
        else $error("write did not allocate its chunk");

endmodule

/* rtl/ctms_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ctms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ctms_addr.sv */
// Two-stage address unit: bounds check, chunk index multiply-add, tile offset.
// Depends on ctms_pkg.
module ctms_addr (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [ctms_pkg::COORD_W-1:0] i_tile_x,
    input  logic [ctms_pkg::COORD_W-1:0] i_tile_y,
    input  logic [ctms_pkg::COORD_W-1:0] i_tile_z,
    input  ctms_pkg::t_cfg         i_cfg,
    output logic                   o_done,
    output ctms_pkg::t_addr        o_addr
);
    import ctms_pkg::*;

    localparam int P_W   = 2 * COUNT_W;
    localparam int YX_W  = 2 * COUNT_W + 1;
    localparam int IDX_W = 3 * COUNT_W + 1;

    logic [SH_W-1:0]            eff_sh;
    logic [COORD_W-1:0]         cx;
    logic [COORD_W-1:0]         cy;
    logic [MAX_CHUNK_SHIFT:0]   mask;
    logic [MAX_CHUNK_SHIFT-1:0] relx;
    logic [MAX_CHUNK_SHIFT-1:0] rely;
    logic [IDX_W-1:0]           idx;

    logic                r1_valid;
    logic                r1_ok;
    logic [COUNT_W-1:0]  r1_z;
    logic [P_W-1:0]      r1_p;
    logic [YX_W-1:0]     r1_yx;
    logic [SLOT_AW-1:0]  r1_off;
    logic                r2_valid;
    t_addr               r2_addr;

    // Effective shift: zero acts as one, clamp at the maximum
    always_comb begin
        if (i_cfg.chunk_shift == '0) begin
            eff_sh = SH_W'(1);
        end else if (int'(i_cfg.chunk_shift) > MAX_CHUNK_SHIFT) begin
            eff_sh = SH_W'(MAX_CHUNK_SHIFT);
        end else begin
            eff_sh = SH_W'(i_cfg.chunk_shift);
        end
    end

    assign cx   = i_tile_x >> eff_sh;
    assign cy   = i_tile_y >> eff_sh;
    assign mask = ((MAX_CHUNK_SHIFT + 1)'(1) << eff_sh) - 1'b1;
    assign relx = i_tile_x[MAX_CHUNK_SHIFT-1:0] & mask[MAX_CHUNK_SHIFT-1:0];
    assign rely = i_tile_y[MAX_CHUNK_SHIFT-1:0] & mask[MAX_CHUNK_SHIFT-1:0];

    // Stage 1: bounds, layer size and in-layer index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r1_ok  <= (cx < COORD_W'(i_cfg.count_x)) && (cy < COORD_W'(i_cfg.count_y)) &&
                      (i_tile_z < COORD_W'(i_cfg.count_z));
            r1_z   <= i_tile_z[COUNT_W-1:0];
            r1_p   <= P_W'(i_cfg.count_y) * P_W'(i_cfg.count_x);
            r1_yx  <= YX_W'(cy[COUNT_W-1:0]) * YX_W'(i_cfg.count_x) +
                      YX_W'(cx[COUNT_W-1:0]);
            r1_off <= (SLOT_AW'(rely) << eff_sh) | SLOT_AW'(relx);
        end
    end

    // Stage 2: full chunk index and store limit
    assign idx = IDX_W'(r1_z) * IDX_W'(r1_p) + IDX_W'(r1_yx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r1_valid) begin
            r2_addr.in_range <= r1_ok && (idx < IDX_W'(MAX_CHUNKS));
            r2_addr.chunk    <= idx[CHUNK_AW-1:0];
            r2_addr.offset   <= r1_off;
        end
    end

    assign o_done = r2_valid;
    assign o_addr = r2_addr;

endmodule
